[rtl/core/knob_quadrature_and_button_qualifier_assert.svh]
// ----------------------------------------------------------------------------
// knob qualifier assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef KNOB_QUADRATURE_AND_BUTTON_QUALIFIER_ASSERT_SVH
`define KNOB_QUADRATURE_AND_BUTTON_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define KQBQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kqbq assertion failed");

// next-cycle implication, disabled during reset
`define KQBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kqbq assertion failed");

`else

`define KQBQ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define KQBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/core/kqbq_pkg.sv]
// ----------------------------------------------------------------------------
// kqbq_pkg
// shared types, constants and helpers of the knob and button qualifier
// ----------------------------------------------------------------------------
package kqbq_pkg;

  // width of the millisecond age counters
  localparam int AGE_BITS = 16;

  localparam int DEBOUNCE_BITS   = 10;
  localparam int LONG_PRESS_BITS = 16;

  // compare width covering both the ages and the limits
  localparam int CMP_BITS = (AGE_BITS > LONG_PRESS_BITS) ? AGE_BITS : LONG_PRESS_BITS;

  localparam logic [DEBOUNCE_BITS-1:0]   DEBOUNCE_RESET   = DEBOUNCE_BITS'(50);
  localparam logic [LONG_PRESS_BITS-1:0] LONG_PRESS_RESET = LONG_PRESS_BITS'(5000);

  // register map
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] REG_DEBOUNCE_ADDR   = ADDR_BITS'(0);
  localparam logic [ADDR_BITS-1:0] REG_LONG_PRESS_ADDR = ADDR_BITS'(4);

  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 8;

  // quadrature pair codes, a in bit 1 and b in bit 0
  localparam logic [1:0] PAIR_00 = 2'b00;
  localparam logic [1:0] PAIR_01 = 2'b01;
  localparam logic [1:0] PAIR_10 = 2'b10;
  localparam logic [1:0] PAIR_11 = 2'b11;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_UP   = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN = 2'sb11;

  // one button sample as seen by the qualifier
  typedef struct packed {
    logic raw;
    logic tick;
  } btn_sample_t;

  // per-sample button events
  typedef struct packed {
    logic click;
    logic long_press;
    logic level;
  } btn_event_t;

  function automatic logic [AGE_BITS-1:0] age_sat_inc(input logic [AGE_BITS-1:0] v);
    return (v == {AGE_BITS{1'b1}}) ? v : v + AGE_BITS'(1);
  endfunction

  function automatic logic signed [1:0] quad_step(input logic [1:0] prev,
                                                  input logic [1:0] now);
    logic signed [1:0] s;
    s = STEP_NONE;
    if ((prev == PAIR_00 && now == PAIR_01) || (prev == PAIR_11 && now == PAIR_10)) begin
      s = STEP_UP;
    end else if ((prev == PAIR_01 && now == PAIR_00) ||
                 (prev == PAIR_10 && now == PAIR_11)) begin
      s = STEP_DOWN;
    end
    return s;
  endfunction

endpackage

[rtl/core/knob_quadrature_and_button_qualifier.sv]
// ----------------------------------------------------------------------------
// knob_quadrature_and_button_qualifier
// Rotary knob decoder with a debounced, long-press aware push button. Each
// input transfer is one sample of knob A, knob B, the active-low button pin
// and a millisecond tick; each one yields exactly one output transfer with
// the detent step (+1, -1 or 0), a click pulse when the debounced button
// becomes pressed, a single long-press pulse per raw-low hold, and the
// current debounced level. A sample is captured in an input register, passes
// through one short layer of compare and counter logic, and lands in the
// output register, so the block sustains one sample per clock while the sink
// does not stall. The output register and the input register together let a
// new sample enter while a finished result still waits on a stalled sink.
// The debounce and long-press limits sit in two APB registers (0x0 and 0x4)
// and should only change while idle.
// ----------------------------------------------------------------------------
`include "knob_quadrature_and_button_qualifier_assert.svh"

module knob_quadrature_and_button_qualifier (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [kqbq_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // knob_a, knob_b, button_level,
                                                           //   ms_tick, pad
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [kqbq_pkg::OUT_TDATA_BITS-1:0]   m_tdata,   // knob_step[1:0], click, long_press,
                                                           //   debounced_level, pad
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [kqbq_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  // configuration registers
  logic [kqbq_pkg::DEBOUNCE_BITS-1:0]   debounce_ms;
  logic [kqbq_pkg::LONG_PRESS_BITS-1:0] long_press_ms;
  logic                                 cfg_write;

  // input register
  logic       in_valid;
  logic       in_knob_a;
  logic       in_knob_b;
  logic       in_button;
  logic       in_tick;
  logic       advance;

  // quadrature state and per-sample results
  logic [1:0]              knob_prev_pair;
  logic [1:0]              knob_now;
  logic signed [1:0]       step;
  kqbq_pkg::btn_sample_t   btn_sample;
  kqbq_pkg::btn_event_t    btn_events;

  // output register
  logic signed [1:0] out_step;
  logic              out_click;
  logic              out_long_press;
  logic              out_level;

  // ---- configuration port ----
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= kqbq_pkg::DEBOUNCE_RESET;
      long_press_ms <= kqbq_pkg::LONG_PRESS_RESET;
    end else if (cfg_write) begin
      if (paddr == kqbq_pkg::REG_DEBOUNCE_ADDR) begin
        debounce_ms <= pwdata[kqbq_pkg::DEBOUNCE_BITS-1:0];
      end else if (paddr == kqbq_pkg::REG_LONG_PRESS_ADDR) begin
        long_press_ms <= pwdata[kqbq_pkg::LONG_PRESS_BITS-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == kqbq_pkg::REG_DEBOUNCE_ADDR) begin
      prdata = 32'(debounce_ms);
    end else if (paddr == kqbq_pkg::REG_LONG_PRESS_ADDR) begin
      prdata = 32'(long_press_ms);
    end
  end

  // ---- handshake ----
  // the working sample moves on whenever the output slot is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register holds one sample until it is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_knob_a <= s_tdata[0];
      in_knob_b <= s_tdata[1];
      in_button <= s_tdata[2];
      in_tick   <= s_tdata[3];
    end
  end

  // ---- quadrature decode ----
  assign knob_now = {in_knob_a, in_knob_b};
  assign step     = kqbq_pkg::quad_step(knob_prev_pair, knob_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      knob_prev_pair <= kqbq_pkg::PAIR_11;   // both pins idle high
    end else if (advance) begin
      knob_prev_pair <= knob_now;
    end
  end

  // ---- button qualifier ----
  assign btn_sample.raw  = in_button;
  assign btn_sample.tick = in_tick;

  kqbq_btn_qual u_btn_qual (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sample        (btn_sample),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .events        (btn_events)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_step       <= step;
      out_click      <= btn_events.click;
      out_long_press <= btn_events.long_press;
      out_level      <= btn_events.level;
    end
  end

  assign m_tdata = {3'b000, out_level, out_long_press, out_click, out_step};

  // a stalled result holds its slot, so no sample may advance over it
  `KQBQ_ASSERT_NOW(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !advance)
  // every processed sample shows up as a result in the next cycle
  `KQBQ_ASSERT_NEXT(a_result_follows, clk, rst, advance, m_tvalid)
  // a held sample keeps the input side closed
  `KQBQ_ASSERT_NOW(a_ready_blocked, clk, rst, in_valid && !advance, !s_tready)

endmodule

[rtl/core/kqbq_btn_qual.sv]
// ----------------------------------------------------------------------------
// kqbq_btn_qual
// button debounce and long-press detection, one sample per advance
// ----------------------------------------------------------------------------
`include "knob_quadrature_and_button_qualifier_assert.svh"

module kqbq_btn_qual (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  kqbq_pkg::btn_sample_t                  sample,
  input  logic [kqbq_pkg::DEBOUNCE_BITS-1:0]     debounce_ms,
  input  logic [kqbq_pkg::LONG_PRESS_BITS-1:0]   long_press_ms,
  output kqbq_pkg::btn_event_t                   events
);

  logic                             last_raw, last_raw_next;
  logic                             stable, stable_next;
  logic [kqbq_pkg::AGE_BITS-1:0]    change_age, change_age_next;
  logic                             hold_active, hold_active_next;
  logic [kqbq_pkg::AGE_BITS-1:0]    hold_age, hold_age_next;
  logic                             fired, fired_next;
  logic                             accept_level;
  logic                             lp;

  always_comb begin
    // debounce
    last_raw_next = sample.raw;
    if (sample.raw != last_raw) begin
      change_age_next = '0;
    end else if (sample.tick) begin
      change_age_next = kqbq_pkg::age_sat_inc(change_age);
    end else begin
      change_age_next = change_age;
    end
    accept_level = (kqbq_pkg::CMP_BITS'(change_age_next) >
                    kqbq_pkg::CMP_BITS'(debounce_ms)) && (sample.raw != stable);
    stable_next  = accept_level ? sample.raw : stable;

    // long press on raw low hold
    lp               = 1'b0;
    hold_active_next = 1'b0;
    hold_age_next    = '0;
    fired_next       = 1'b0;
    if (!sample.raw) begin
      hold_active_next = 1'b1;
      if (hold_active) begin
        hold_age_next = sample.tick ? kqbq_pkg::age_sat_inc(hold_age) : hold_age;
        lp            = (kqbq_pkg::CMP_BITS'(hold_age_next) >
                         kqbq_pkg::CMP_BITS'(long_press_ms)) && !fired;
        fired_next    = fired | lp;
      end
    end

    events.click      = accept_level && !sample.raw;
    events.long_press = lp;
    events.level      = stable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw    <= 1'b1;
      stable      <= 1'b1;
      change_age  <= '0;
      hold_active <= 1'b0;
      hold_age    <= '0;
      fired       <= 1'b0;
    end else if (advance) begin
      last_raw    <= last_raw_next;
      stable      <= stable_next;
      change_age  <= change_age_next;
      hold_active <= hold_active_next;
      hold_age    <= hold_age_next;
      fired       <= fired_next;
    end
  end

  // a click always reports the pressed level
  `KQBQ_ASSERT_NOW(a_click_low, clk, rst, advance && events.click, !events.level)
  // a long press latches the fired flag until release
  `KQBQ_ASSERT_NEXT(a_lp_latched, clk, rst, advance && events.long_press, fired && hold_active)
  // a released sample clears the whole hold state
  `KQBQ_ASSERT_NEXT(a_release_clears, clk, rst, advance && sample.raw,
                    !hold_active && (hold_age == '0) && !fired)
  // an unarmed hold counter stays at zero
  `KQBQ_ASSERT_NOW(a_idle_age_zero, clk, rst, !hold_active, (hold_age == '0) && !fired)

endmodule

[dv/knob_quadrature_and_button_qualifier_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knob qualifier checker
// Watches the sample, result and register channels, keeps its own copy of
// the decoder and debouncer state and compares every result transfer
// ----------------------------------------------------------------------------
module knob_quadrature_and_button_qualifier_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  input  logic                                  s_tready,
  input  logic [kqbq_pkg::IN_TDATA_BITS-1:0]    s_tdata,
  input  logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic [kqbq_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [kqbq_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  input  logic                                  pready,
  output int                                    errors,
  output int                                    outstanding
);

  typedef struct packed {
    logic signed [1:0] step;
    logic              click;
    logic              long_press;
    logic              level;
  } knob_report_t;

  logic [kqbq_pkg::DEBOUNCE_BITS-1:0]   debounce_lim;
  logic [kqbq_pkg::LONG_PRESS_BITS-1:0] hold_lim;

  logic [1:0]                    last_pair;
  logic                          last_raw;
  logic                          stable_lvl;
  logic [kqbq_pkg::AGE_BITS-1:0] change_age;
  logic                          holding;
  logic [kqbq_pkg::AGE_BITS-1:0] hold_age;
  logic                          lp_done;

  knob_report_t knob_reports_q[$];

  task automatic note_mismatch(input string field, input int want, input int got);
    $display("%0t mismatch %s: want %0d got %0d", $time, field, want, got);
    errors++;
  endtask

  // one sample through the decoder, the debouncer and the hold counter
  task automatic qualify_sample(input logic [kqbq_pkg::IN_TDATA_BITS-1:0] d,
                                output knob_report_t r);
    logic [1:0] pair;
    logic       raw;
    logic       tick;
    pair = {d[0], d[1]};
    raw  = d[2];
    tick = d[3];
    r    = '0;

    case ({last_pair, pair})
      {kqbq_pkg::PAIR_00, kqbq_pkg::PAIR_01},
      {kqbq_pkg::PAIR_11, kqbq_pkg::PAIR_10}: r.step = kqbq_pkg::STEP_UP;
      {kqbq_pkg::PAIR_01, kqbq_pkg::PAIR_00},
      {kqbq_pkg::PAIR_10, kqbq_pkg::PAIR_11}: r.step = kqbq_pkg::STEP_DOWN;
      default: r.step = kqbq_pkg::STEP_NONE;
    endcase
    last_pair = pair;

    // a level change restarts the age and swallows this tick
    if (raw != last_raw) begin
      last_raw   = raw;
      change_age = '0;
    end else if (tick && change_age != '1) begin
      change_age = change_age + kqbq_pkg::AGE_BITS'(1);
    end
    if (change_age > debounce_lim && raw != stable_lvl) begin
      stable_lvl = raw;
      r.click    = !raw;
    end

    if (!raw) begin
      if (!holding) begin
        holding  = 1'b1;
        hold_age = '0;
      end else begin
        if (tick && hold_age != '1) begin
          hold_age = hold_age + kqbq_pkg::AGE_BITS'(1);
        end
        if (hold_age > hold_lim && !lp_done) begin
          lp_done      = 1'b1;
          r.long_press = 1'b1;
        end
      end
    end else begin
      holding  = 1'b0;
      hold_age = '0;
      lp_done  = 1'b0;
    end

    r.level = stable_lvl;
  endtask

  always @(posedge clk) begin : watch
    knob_report_t want;
    knob_report_t got;
    if (rst) begin
      debounce_lim = kqbq_pkg::DEBOUNCE_RESET;
      hold_lim     = kqbq_pkg::LONG_PRESS_RESET;
      last_pair    = kqbq_pkg::PAIR_11;
      last_raw     = 1'b1;
      stable_lvl   = 1'b1;
      change_age   = '0;
      holding      = 1'b0;
      hold_age     = '0;
      lp_done      = 1'b0;
      errors       = 0;
      knob_reports_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == kqbq_pkg::REG_DEBOUNCE_ADDR) begin
          debounce_lim = pwdata[kqbq_pkg::DEBOUNCE_BITS-1:0];
        end else if (paddr == kqbq_pkg::REG_LONG_PRESS_ADDR) begin
          hold_lim = pwdata[kqbq_pkg::LONG_PRESS_BITS-1:0];
        end
      end
      if (s_tvalid && s_tready) begin
        qualify_sample(s_tdata, want);
        knob_reports_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.step       = m_tdata[1:0];
        got.click      = m_tdata[2];
        got.long_press = m_tdata[3];
        got.level      = m_tdata[4];
        if (knob_reports_q.size() == 0) begin
          note_mismatch("result with nothing pending", 0, int'(m_tdata));
        end else begin
          want = knob_reports_q.pop_front();
          if (got.step !== want.step) begin
            note_mismatch("knob_step", int'(want.step), int'(got.step));
          end
          if (got.click !== want.click) begin
            note_mismatch("click", int'(want.click), int'(got.click));
          end
          if (got.long_press !== want.long_press) begin
            note_mismatch("long_press", int'(want.long_press), int'(got.long_press));
          end
          if (got.level !== want.level) begin
            note_mismatch("debounced_level", int'(want.level), int'(got.level));
          end
        end
      end
      outstanding <= knob_reports_q.size();
    end
  end

endmodule

[dv/knob_quadrature_and_button_qualifier_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knob qualifier testbench
// Drives knob and button samples through the qualifier under several debounce
// and long-press settings, with random idling on both streams, a long sink
// hold-off and a phase of long button holds; the checker judges every result
// ----------------------------------------------------------------------------
module knob_quadrature_and_button_qualifier_test;

  // cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // samples accepted before the sink holds off for a long stretch
  localparam int HOLD_OFF_AT  = 120;
  localparam int HOLD_OFF_LEN = 64;

  logic                                 clk;
  logic                                 rst      = 1'b1;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [kqbq_pkg::IN_TDATA_BITS-1:0]   s_tdata  = '0;  // knob_a, knob_b, button_level,
                                                        //   ms_tick, pad
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [kqbq_pkg::OUT_TDATA_BITS-1:0]  m_tdata;        // knob_step[1:0], click,
                                                        //   long_press, level, pad
  logic                                 psel     = 1'b0;
  logic                                 penable  = 1'b0;
  logic                                 pwrite   = 1'b0;
  logic [kqbq_pkg::ADDR_BITS-1:0]       paddr    = '0;
  logic [31:0]                          pwdata   = '0;
  logic [31:0]                          prdata;
  logic                                 pready;

  int errors;
  int outstanding;

  // percent of cycles in which each side idles, dropped to zero for one phase
  int idle_pct = 17;
  int sent     = 0;

  // binary position of the knob, turned into a gray pair for well-formed rotation
  logic [1:0] knob_pos = 2'd3;
  logic       knob_dir = 1'b0;

  // walk over every ordered pair of knob states, starting from the idle pair
  logic [1:0] knob_tour [17] = '{kqbq_pkg::PAIR_00, kqbq_pkg::PAIR_00, kqbq_pkg::PAIR_01,
                                 kqbq_pkg::PAIR_01, kqbq_pkg::PAIR_10, kqbq_pkg::PAIR_10,
                                 kqbq_pkg::PAIR_11, kqbq_pkg::PAIR_11, kqbq_pkg::PAIR_00,
                                 kqbq_pkg::PAIR_10, kqbq_pkg::PAIR_00, kqbq_pkg::PAIR_11,
                                 kqbq_pkg::PAIR_01, kqbq_pkg::PAIR_11, kqbq_pkg::PAIR_10,
                                 kqbq_pkg::PAIR_01, kqbq_pkg::PAIR_00};

  knob_quadrature_and_button_qualifier dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  knob_quadrature_and_button_qualifier_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one sample and hold it until the transfer; valid stays high into
  // the next sample unless that one starts with idle cycles
  task automatic send_sample(input logic [1:0] pair, input logic btn, input logic tick);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, tick, btn, pair[0], pair[1]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // stop offering, wait for every pending result, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access phase; psel stays high so writes can go back to back
  task automatic apb_write(input logic [kqbq_pkg::ADDR_BITS-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] deb, input logic [31:0] hold);
    apb_write(kqbq_pkg::REG_DEBOUNCE_ADDR, deb);
    apb_write(kqbq_pkg::REG_LONG_PRESS_ADDR, hold);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // button runs of random length, some starting with bounce, while the knob
  // mostly turns through legal gray steps with direction changes and skips
  task automatic sample_burst(input int count, input int span);
    int         left;
    int         len;
    int         k;
    int         roll;
    logic       lvl;
    logic       bouncy;
    logic       btn;
    logic [1:0] pair;
    left = count;
    while (left > 0) begin
      lvl    = 1'($urandom_range(0, 1));
      len    = $urandom_range(1, span);
      bouncy = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len && left > 0; k++) begin
        btn  = (bouncy && k < 4) ? 1'($urandom_range(0, 1)) : lvl;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          knob_dir = ~knob_dir;
        end
        if (roll < 75) begin
          knob_pos = knob_dir ? knob_pos - 2'd1 : knob_pos + 2'd1;
          pair     = {knob_pos[1], knob_pos[1] ^ knob_pos[0]};
        end else if (roll < 92) begin
          pair = {knob_pos[1], knob_pos[1] ^ knob_pos[0]};
        end else begin
          // skipped or arbitrary state, then resume the walk from there
          pair     = 2'($urandom_range(0, 3));
          knob_pos = {pair[1], pair[1] ^ pair[0]};
        end
        send_sample(pair, btn, $urandom_range(0, 99) < 60);
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] deb, input logic [31:0] hold,
                           input int count, input int span, input bit calm);
    settle();
    set_limits(deb, hold);
    idle_pct = calm ? 0 : 17;
    sample_burst(count, span);
    idle_pct = 17;
  endtask

  // sink side: random backpressure plus one long hold-off while the source
  // keeps offering, so the block fills and stalls its input
  initial begin : sink
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!held && sent >= HOLD_OFF_AT) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_LEN - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // hang detection: any transfer on either stream restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset limits: every knob transition, button high, random ticks
    for (i = 0; i < 17; i++) begin
      send_sample(knob_tour[i], 1'b1, 1'($urandom_range(0, 1)));
    end
    // press without tick arms the hold, tick counts, release clears it
    send_sample(kqbq_pkg::PAIR_00, 1'b0, 1'b0);
    send_sample(kqbq_pkg::PAIR_00, 1'b0, 1'b1);
    send_sample(kqbq_pkg::PAIR_00, 1'b1, 1'b1);

    // zero limits, written with junk above the register width
    settle();
    set_limits(32'hFFFF_FC00, 32'hFFFF_0000);
    send_sample(kqbq_pkg::PAIR_00, 1'b0, 1'b0);  // change restarts the age, no click yet
    send_sample(kqbq_pkg::PAIR_00, 1'b0, 1'b1);  // click and long press together
    send_sample(kqbq_pkg::PAIR_00, 1'b0, 1'b1);  // long press fires once per hold
    send_sample(kqbq_pkg::PAIR_00, 1'b1, 1'b0);  // release clears hold
    send_sample(kqbq_pkg::PAIR_00, 1'b1, 1'b1);  // debounced level returns high

    // random phases across settings; the third one runs with no idling
    run_phase(32'd0, 32'd0, 160, 6, 1'b0);
    run_phase(32'd1, 32'd2, 160, 10, 1'b0);
    run_phase(32'd3, 32'd12, 160, 40, 1'b1);
    run_phase(32'd1000, 32'd65535, 120, 60, 1'b0);
    run_phase(32'd2, 32'd5, 160, 16, 1'b0);
    run_phase($urandom_range(0, 6), $urandom_range(0, 30), 160, 24, 1'b0);
    // long button holds that pass a moderate long-press limit
    run_phase(32'd4, 32'd60, 150, 150, 1'b0);

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
